@@ sv/byte_neighbor_average_blur_assert.svh @@
// assertion macros for the neighbor average blur
`ifndef BYTE_NEIGHBOR_AVERAGE_BLUR_ASSERT_SVH
`define BYTE_NEIGHBOR_AVERAGE_BLUR_ASSERT_SVH

// same-cycle implication, checked on every rising clk edge out of reset
`define BNAB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BNAB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bnab_pkg.sv @@
// shared types and constants of the neighbor average blur
`default_nettype none

package bnab_pkg;

  localparam int MAX_ROW_BYTES_DEF   = 8192;
  localparam int MAX_IMAGE_BYTES_DEF = 16777215;

  localparam int STRIDE_W   = 14;
  localparam int SIZE_W     = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [STRIDE_W-1:0] STRIDE_RST = 14'd1920;
  localparam logic [SIZE_W-1:0]   SIZE_RST   = 24'd921600;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE = 1'd1;

  // same channel one pixel away
  localparam int PIXEL_STEP = 3;

  // floor(x / 3) == (x * 683) >> 11 for x up to 1020
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;

  typedef struct packed {
    logic       action;
    logic [7:0] pixel_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] blurred_byte;
    logic       out_last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_NEAR,
    S_RD_FAR,
    S_SUM,
    S_DIV,
    S_OUT
  } bnab_state_t;

endpackage

`default_nettype wire

@@ sv/byte_neighbor_average_blur.sv @@
// neighbor average blur over a 24-bit image byte stream
// an emitting beat walks near reads, far reads, sum, divide and output before its result shows
// throughput: 1 beat per cycle when no result is due; a beat that emits one holds off the next beat
//   through two reads of the two-port line ring plus the sum, divide and output steps
// reset: synchronous active-low, clears positions, sequencer, output valid, registers
// the line ring is not cleared; every entry is written before it is read in an image
`default_nettype none

module byte_neighbor_average_blur #(
  parameter int MAX_ROW_BYTES   = bnab_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_IMAGE_BYTES = bnab_pkg::MAX_IMAGE_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input beats
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire bnab_pkg::in_t                    in_data,
  // result beats
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output bnab_pkg::out_t                        out_data,
  // register writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bnab_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bnab_pkg::CFG_DATA_W-1:0]  cfg_data
);

`include "byte_neighbor_average_blur_assert.svh"

  // ring depth: a row plus a little slack, addressed by position modulo depth
  localparam int DEPTH  = MAX_ROW_BYTES + 4;
  localparam int AW     = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(MAX_ROW_BYTES + 1);
  localparam int POS_W  = $clog2(MAX_IMAGE_BYTES + 1);
  localparam int SCW    = (ROW_W > bnab_pkg::STRIDE_W) ? ROW_W : bnab_pkg::STRIDE_W;
  localparam int SZW    = (POS_W > bnab_pkg::SIZE_W) ? POS_W : bnab_pkg::SIZE_W;
  // room for a position plus a stride without wrapping
  localparam int PW     = ((POS_W > ROW_W) ? POS_W : ROW_W) + 1;
  localparam int PROD_W = 20;

  // ---------------------------------------------------------------------------
  // configuration registers, always ready
  // ---------------------------------------------------------------------------
  logic [bnab_pkg::STRIDE_W-1:0] row_stride_r;
  logic [bnab_pkg::SIZE_W-1:0]   image_size_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_stride_r <= bnab_pkg::STRIDE_RST;
      image_size_r <= bnab_pkg::SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bnab_pkg::CFG_ROW_STRIDE: row_stride_r <= cfg_data[bnab_pkg::STRIDE_W-1:0];
        bnab_pkg::CFG_IMAGE_SIZE: image_size_r <= cfg_data[bnab_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // stride clamped to 3 .. MAX_ROW_BYTES, size clamped to MAX_IMAGE_BYTES
  logic [SCW-1:0]   stride_ext;
  logic [SZW-1:0]   size_ext;
  logic [ROW_W-1:0] stride_eff;
  logic [POS_W-1:0] size_eff;

  always_comb begin
    stride_ext = SCW'(row_stride_r);
    size_ext   = SZW'(image_size_r);
    if (stride_ext < SCW'(bnab_pkg::PIXEL_STEP)) begin
      stride_eff = ROW_W'(bnab_pkg::PIXEL_STEP);
    end else if (stride_ext > SCW'(MAX_ROW_BYTES)) begin
      stride_eff = ROW_W'(MAX_ROW_BYTES);
    end else begin
      stride_eff = ROW_W'(stride_ext);
    end
    if (size_ext > SZW'(MAX_IMAGE_BYTES)) begin
      size_eff = POS_W'(MAX_IMAGE_BYTES);
    end else begin
      size_eff = POS_W'(size_ext);
    end
  end

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  bnab_pkg::bnab_state_t state_r, state_nxt;

  // byte counts of the current image and their ring addresses
  logic [POS_W-1:0] in_pos_r,  in_pos_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [AW-1:0]    wr_addr_r, wr_addr_nxt;
  logic [AW-1:0]    rd_addr_r, rd_addr_nxt;

  // neighbor addresses and presence of the result under way
  logic [AW-1:0] addr_self_r,  addr_self_nxt;
  logic [AW-1:0] addr_left_r,  addr_left_nxt;
  logic [AW-1:0] addr_right_r, addr_right_nxt;
  logic [AW-1:0] addr_row_r,   addr_row_nxt;
  logic          has_left_r,   has_left_nxt;
  logic          has_right_r,  has_right_nxt;
  logic          has_row_r,    has_row_nxt;
  logic          last_r,       last_nxt;
  logic [1:0]    nb_cnt_r,     nb_cnt_nxt;

  // arithmetic stages
  logic [8:0]        near_sum_r;
  logic [9:0]        sum_r;
  logic [PROD_W-1:0] prod_r;
  logic [7:0]        quot;

  // output register
  logic           out_valid_r, out_valid_nxt;
  bnab_pkg::out_t out_data_r;
  logic           out_load;

  // line ring: one write port, two read ports with registered data
  logic [7:0]    line_store [DEPTH];
  logic [7:0]    rd_q0_r, rd_q1_r;
  logic [AW-1:0] rd_a0, rd_a1;
  logic          mem_we;
  logic [AW-1:0] mem_wa;

  // accept decision working values
  logic          accept;
  logic          wrap;
  logic          emit;
  logic [POS_W-1:0] ip0, op0, ip1;
  logic [AW-1:0]    wa0, ra0;
  logic [AW:0]      right_sum, row_sum;

  assign in_stall  = (state_r != bnab_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bnab_pkg::S_IDLE;
      in_pos_r    <= '0;
      out_pos_r   <= '0;
      wr_addr_r   <= '0;
      rd_addr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_pos_r    <= in_pos_nxt;
      out_pos_r   <= out_pos_nxt;
      wr_addr_r   <= wr_addr_nxt;
      rd_addr_r   <= rd_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result bookkeeping, payload only
  always_ff @(posedge clk) begin
    addr_self_r  <= addr_self_nxt;
    addr_left_r  <= addr_left_nxt;
    addr_right_r <= addr_right_nxt;
    addr_row_r   <= addr_row_nxt;
    has_left_r   <= has_left_nxt;
    has_right_r  <= has_right_nxt;
    has_row_r    <= has_row_nxt;
    last_r       <= last_nxt;
    nb_cnt_r     <= nb_cnt_nxt;
  end

  // ---------------------------------------------------------------------------
  // sequencer: idle takes a beat, writes it unless it is an action beat or past the image end,
  // and decides whether a result is due; a result walks near reads, far reads, sum, divide, output
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    in_pos_nxt     = in_pos_r;
    out_pos_nxt    = out_pos_r;
    wr_addr_nxt    = wr_addr_r;
    rd_addr_nxt    = rd_addr_r;
    addr_self_nxt  = addr_self_r;
    addr_left_nxt  = addr_left_r;
    addr_right_nxt = addr_right_r;
    addr_row_nxt   = addr_row_r;
    has_left_nxt   = has_left_r;
    has_right_nxt  = has_right_r;
    has_row_nxt    = has_row_r;
    last_nxt       = last_r;
    nb_cnt_nxt     = nb_cnt_r;
    mem_we         = 1'b0;
    out_load       = 1'b0;
    rd_a0          = addr_self_r;
    rd_a1          = addr_left_r;
    emit           = 1'b0;

    // a finished image restarts both counts at the start of a beat
    wrap = (in_pos_r >= size_eff) && (out_pos_r >= size_eff);
    ip0  = wrap ? '0 : in_pos_r;
    op0  = wrap ? '0 : out_pos_r;
    wa0  = wrap ? '0 : wr_addr_r;
    ra0  = wrap ? '0 : rd_addr_r;
    ip1  = ip0 + POS_W'(1);
    mem_wa = wa0;

    // neighbor ring addresses for position op0
    right_sum = (AW+1)'(ra0) + (AW+1)'(bnab_pkg::PIXEL_STEP);
    row_sum   = (AW+1)'(ra0) + (AW+1)'(stride_eff);

    case (state_r)
      bnab_pkg::S_IDLE: begin
        if (accept) begin
          in_pos_nxt  = ip0;
          out_pos_nxt = op0;
          wr_addr_nxt = wa0;
          rd_addr_nxt = ra0;
          if (ip0 < size_eff) begin
            if (!in_data.action) begin
              mem_we      = 1'b1;
              in_pos_nxt  = ip1;
              wr_addr_nxt = (wa0 == AW'(DEPTH - 1)) ? '0 : wa0 + AW'(1);
              // a full row of lookahead is buffered
              emit = (PW'(ip1 - op0) > PW'(stride_eff));
            end
          end else begin
            // tail of the image, one result per beat
            emit = (op0 < size_eff);
          end

          if (emit) begin
            addr_self_nxt = ra0;
            addr_left_nxt = (ra0 >= AW'(bnab_pkg::PIXEL_STEP)) ?
                            AW'(ra0 - AW'(bnab_pkg::PIXEL_STEP)) :
                            AW'((AW+1)'(ra0) + (AW+1)'(DEPTH - bnab_pkg::PIXEL_STEP));
            addr_right_nxt = (right_sum >= (AW+1)'(DEPTH)) ?
                             AW'(right_sum - (AW+1)'(DEPTH)) : AW'(right_sum);
            addr_row_nxt   = (row_sum >= (AW+1)'(DEPTH)) ?
                             AW'(row_sum - (AW+1)'(DEPTH)) : AW'(row_sum);
            has_left_nxt  = (PW'(op0) >= PW'(bnab_pkg::PIXEL_STEP));
            has_right_nxt = (PW'(op0) + PW'(bnab_pkg::PIXEL_STEP) < PW'(size_eff));
            has_row_nxt   = (PW'(op0) + PW'(stride_eff) < PW'(size_eff));
            last_nxt      = (PW'(op0) + PW'(1) == PW'(size_eff));
            nb_cnt_nxt    = 2'(has_left_nxt) + 2'(has_right_nxt) + 2'(has_row_nxt);
            out_pos_nxt   = op0 + POS_W'(1);
            rd_addr_nxt   = (ra0 == AW'(DEPTH - 1)) ? '0 : ra0 + AW'(1);
            state_nxt     = bnab_pkg::S_RD_NEAR;
          end
        end
      end

      bnab_pkg::S_RD_NEAR: begin
        rd_a0     = addr_self_r;
        rd_a1     = addr_left_r;
        state_nxt = bnab_pkg::S_RD_FAR;
      end

      bnab_pkg::S_RD_FAR: begin
        rd_a0     = addr_right_r;
        rd_a1     = addr_row_r;
        state_nxt = bnab_pkg::S_SUM;
      end

      bnab_pkg::S_SUM: begin
        state_nxt = bnab_pkg::S_DIV;
      end

      bnab_pkg::S_DIV: begin
        state_nxt = bnab_pkg::S_OUT;
      end

      bnab_pkg::S_OUT: begin
        // hold until the previous result has been taken
        if (!(out_valid_r && out_stall)) begin
          out_load  = 1'b1;
          state_nxt = bnab_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bnab_pkg::S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // ring write and the two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[mem_wa] <= in_data.pixel_byte;
    end
    rd_q0_r <= line_store[rd_a0];
    rd_q1_r <= line_store[rd_a1];
  end

  // ---------------------------------------------------------------------------
  // datapath: self + left, then + right + row, then divide by 1..4
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_r == bnab_pkg::S_RD_FAR) begin
      // read data holds self and left here
      near_sum_r <= 9'(rd_q0_r) + (has_left_r ? 9'(rd_q1_r) : 9'd0);
    end
    if (state_r == bnab_pkg::S_SUM) begin
      // read data holds right and row here
      sum_r <= 10'(near_sum_r) + (has_right_r ? 10'(rd_q0_r) : 10'd0)
                               + (has_row_r   ? 10'(rd_q1_r) : 10'd0);
    end
    if (state_r == bnab_pkg::S_DIV) begin
      prod_r <= PROD_W'(sum_r) * PROD_W'(bnab_pkg::DIV3_MUL);
    end
    if (out_load) begin
      out_data_r.blurred_byte <= quot;
      out_data_r.out_last     <= last_r;
    end
  end

  // divisor is one more than the neighbor count
  always_comb begin
    case (nb_cnt_r)
      2'd0:    quot = sum_r[7:0];
      2'd1:    quot = sum_r[8:1];
      2'd2:    quot = prod_r[bnab_pkg::DIV3_SHIFT+7:bnab_pkg::DIV3_SHIFT];
      default: quot = sum_r[9:2];
    endcase
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `BNAB_ASSERT_NOW(a_out_pos_trails, 1'b1, out_pos_r <= in_pos_r, "output count passed input count")
  `BNAB_ASSERT_NOW(a_ring_addr_range, 1'b1, wr_addr_r <= AW'(DEPTH - 1), "write address beyond ring")
  `BNAB_ASSERT_NEXT(a_out_load, (state_r == bnab_pkg::S_OUT) && !(out_valid_r && out_stall), out_valid_r && (state_r == bnab_pkg::S_IDLE), "result not loaded")
  `BNAB_ASSERT_NEXT(a_near_then_far, state_r == bnab_pkg::S_RD_NEAR, state_r == bnab_pkg::S_RD_FAR, "read sequence broken")

endmodule

`default_nettype wire
